// File: rtl/core/crrp_pkg.sv
// Shared types and constants of the capacity-aware round-robin picker.
`timescale 1ns / 1ps
`default_nettype none

package crrp_pkg;

  // Field widths fixed by the item format.
  localparam int ID_W   = 4;
  localparam int LOAD_W = 8;
  localparam int CFG_W  = 8;
  localparam int CFG_IDX_W = 2;

  // Default table depth.
  localparam int NODE_COUNT_DEF = 16;

  // Operation codes.
  localparam logic [1:0] OP_ADD_NODE = 2'd0;
  localparam logic [1:0] OP_ADD_LOAD = 2'd1;
  localparam logic [1:0] OP_SET_STAT = 2'd2;
  localparam logic [1:0] OP_PICK     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ALLOWED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANN_MAX_LOAD = 2'd2;

  // Configuration reset values.
  localparam logic [ID_W-1:0]   OWN_ID_RST       = 4'd0;
  localparam logic [LOAD_W-1:0] OWN_ALLOWED_RST  = 8'd2;
  localparam logic [LOAD_W-1:0] ANN_MAX_LOAD_RST = 8'd8;

  localparam logic [LOAD_W-1:0] LOAD_MAX = 8'hFF;

  // One table entry.
  typedef struct packed {
    logic              present;
    logic [LOAD_W-1:0] load;
    logic [LOAD_W-1:0] allowed;
  } entry_t;

  // Configuration values seen by the sequencer.
  typedef struct packed {
    logic [ID_W-1:0]   own_id;
    logic [LOAD_W-1:0] own_allowed;
    logic [LOAD_W-1:0] ann_max_load;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [ID_W-1:0]   host_id;
    logic              status;
    logic              announce;
    logic [LOAD_W-1:0] announce_load;
    logic [LOAD_W-1:0] announce_allowed;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/capacity_aware_round_robin_picker_top.sv
// Top level: configuration registers, node table and sequencer.
// Add, add-load and set-status go through a table read request, RAM read data and
// write-back, and the output register load, which waits while the output is stalled.
// A pick scans one table entry per cycle through the single RAM read port until a hit
// or the whole table is read; one item is in work at a time and the next transfer can
// come in the cycle after the result loads.
// Reset clears the present bits, sets the round-robin pointer to the last index
// and loads the configuration defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module capacity_aware_round_robin_picker_top #(
  parameter int NODE_COUNT = crrp_pkg::NODE_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     opcode,
  input  wire logic [crrp_pkg::ID_W-1:0]      node_id,
  input  wire logic [crrp_pkg::LOAD_W-1:0]    new_load,
  input  wire logic [crrp_pkg::LOAD_W-1:0]    new_allowed,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [crrp_pkg::ID_W-1:0]           host_id,
  output logic                                status,
  output logic                                announce,
  output logic [crrp_pkg::LOAD_W-1:0]         announce_load,
  output logic [crrp_pkg::LOAD_W-1:0]         announce_allowed,
  input  wire logic                           cfg_wr_en,
  input  wire logic [crrp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [crrp_pkg::CFG_W-1:0]     cfg_wr_data
);
  import crrp_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);

  cfg_t             cfg;
  res_t             out_res;
  entry_t           rd_entry, wr_entry;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_id       <= OWN_ID_RST;
      cfg.own_allowed  <= OWN_ALLOWED_RST;
      cfg.ann_max_load <= ANN_MAX_LOAD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_OWN_ID:       cfg.own_id       <= cfg_wr_data[ID_W-1:0];
        CFG_OWN_ALLOWED:  cfg.own_allowed  <= cfg_wr_data;
        CFG_ANN_MAX_LOAD: cfg.ann_max_load <= cfg_wr_data;
        default:          cfg.own_id       <= cfg.own_id;
      endcase
    end
  end

  crrp_table #(
    .NODE_COUNT(NODE_COUNT),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_entry(rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_entry(wr_entry)
  );

  crrp_seq #(
    .NODE_COUNT(NODE_COUNT),
    .IDX_W     (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .node_id    (node_id),
    .new_load   (new_load),
    .new_allowed(new_allowed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_entry   (rd_entry),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_entry   (wr_entry)
  );

  // Result fields onto their ports.
  assign host_id          = out_res.host_id;
  assign status           = out_res.status;
  assign announce         = out_res.announce;
  assign announce_load    = out_res.announce_load;
  assign announce_allowed = out_res.announce_allowed;

endmodule

`default_nettype wire

// File: rtl/core/crrp_table.sv
// Node table: present bits in flip-flops, load and allowed load in a synchronous RAM.
`timescale 1ns / 1ps
`default_nettype none

module crrp_table #(
  parameter int NODE_COUNT = crrp_pkg::NODE_COUNT_DEF,
  parameter int IDX_W = $clog2(NODE_COUNT)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output crrp_pkg::entry_t      rd_entry,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  crrp_pkg::entry_t      wr_entry
);
  import crrp_pkg::*;

  logic [NODE_COUNT-1:0]   present;
  logic [2*LOAD_W-1:0]     mem [NODE_COUNT];
  logic                    rd_present;
  logic [2*LOAD_W-1:0]     rd_word;

  // Present bits clear at reset; a write sets the addressed one.
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (wr_en) begin
      present[wr_addr] <= wr_entry.present;
    end
  end

  // Load and allowed load live in the RAM, written and read in one port each.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_entry.load, wr_entry.allowed};
    end
  end

  // Registered read: entry data appears in the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_present <= present[rd_addr];
      rd_word    <= mem[rd_addr];
    end
  end

  assign rd_entry.present = rd_present;
  assign rd_entry.load    = rd_word[2*LOAD_W-1:LOAD_W];
  assign rd_entry.allowed = rd_word[LOAD_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/crrp_seq.sv
// Sequencer: read-modify-write of table entries, the pick scan and the result register.
`timescale 1ns / 1ps
`default_nettype none

module crrp_seq #(
  parameter int NODE_COUNT = crrp_pkg::NODE_COUNT_DEF,
  parameter int IDX_W = $clog2(NODE_COUNT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  crrp_pkg::cfg_t                   cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  opcode,
  input  wire logic [crrp_pkg::ID_W-1:0]   node_id,
  input  wire logic [crrp_pkg::LOAD_W-1:0] new_load,
  input  wire logic [crrp_pkg::LOAD_W-1:0] new_allowed,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output crrp_pkg::res_t                   out_res,
  output logic                             rd_en,
  output logic [IDX_W-1:0]                 rd_addr,
  input  crrp_pkg::entry_t                 rd_entry,
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_addr,
  output crrp_pkg::entry_t                 wr_entry
);
  import crrp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
  localparam logic [IDX_W:0]   SCAN_LEN = (IDX_W+1)'(NODE_COUNT);

  logic [2:0]        state, state_next;
  logic [1:0]        op;
  logic [ID_W-1:0]   id;
  logic [LOAD_W-1:0] nload, nallow;
  logic [IDX_W-1:0]  rr_pointer;
  logic [IDX_W-1:0]  scan_addr;
  logic [IDX_W-1:0]  eval_addr;
  logic [IDX_W:0]    iss_cnt;
  logic              pend;
  res_t              res, res_next;
  logic              in_xfer, out_free;
  logic              id_in_range, id_present, issue, hit;
  logic [IDX_W-1:0]  id_addr, ptr_succ;
  logic [LOAD_W-1:0] load_inc;

  assign in_xfer     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE);
  assign id_in_range = (32'(id) < 32'(NODE_COUNT));
  assign id_addr     = IDX_W'(id);
  assign id_present  = id_in_range && rd_entry.present;
  assign ptr_succ    = (rr_pointer == LAST_IDX) ? '0 : rr_pointer + 1'b1;
  assign issue       = (state == ST_SCAN) && (iss_cnt < SCAN_LEN);
  assign hit         = pend && rd_entry.present && (rd_entry.allowed > rd_entry.load);
  assign load_inc    = (rd_entry.load == LOAD_MAX) ? LOAD_MAX : rd_entry.load + 1'b1;

  // Table read requests: the addressed entry, or the next scan slot.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = id_addr;
    if (state == ST_READ) begin
      rd_en = 1'b1;
    end else if (issue) begin
      rd_en   = 1'b1;
      rd_addr = scan_addr;
    end
  end

  // Write-back of the modified entry.
  always_comb begin
    wr_addr          = id_addr;
    wr_entry.present = 1'b1;
    wr_entry.load    = '0;
    wr_entry.allowed = '0;
    wr_en            = 1'b0;
    if (state == ST_MOD) begin
      case (op)
        OP_ADD_NODE: begin
          wr_en            = id_in_range;
          wr_entry.allowed = (id == cfg.own_id) ? cfg.own_allowed : '0;
        end
        OP_ADD_LOAD: begin
          wr_en            = id_present;
          wr_entry.load    = load_inc;
          wr_entry.allowed = rd_entry.allowed;
        end
        OP_SET_STAT: begin
          wr_en            = id_present;
          wr_entry.load    = nload;
          wr_entry.allowed = nallow;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // Pending result: a table update sets it in the modify cycle, a pick during the scan.
  always_comb begin
    res_next = res;
    if (state == ST_MOD) begin
      res_next = '0;
      case (op)
        OP_ADD_NODE: begin
          if (id_in_range) begin
            res_next.announce         = 1'b1;
            res_next.announce_allowed = cfg.ann_max_load;
          end else begin
            res_next.status = 1'b1;
          end
        end
        OP_ADD_LOAD: begin
          res_next.status = !id_present;
        end
        OP_SET_STAT: begin
          res_next.status = !id_present;
          if (id_present && id == cfg.own_id) begin
            res_next.announce         = 1'b1;
            res_next.announce_load    = nload;
            res_next.announce_allowed = nallow;
          end
        end
        default: begin
          res_next.status = 1'b0;
        end
      endcase
    end else if (state == ST_SCAN) begin
      res_next         = '0;
      res_next.host_id = hit ? ID_W'(eval_addr) : cfg.own_id;
    end
  end

  // State transitions.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (opcode == OP_PICK) ? ST_SCAN : ST_READ;
        end
      end
      ST_READ: state_next = ST_MOD;
      ST_MOD:  state_next = ST_RESP;
      ST_SCAN: begin
        if (hit || (pend && iss_cnt == SCAN_LEN)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rr_pointer <= LAST_IDX;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if ((state == ST_SCAN) && hit) begin
        rr_pointer <= eval_addr;
      end
      if ((state == ST_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Captured item, scan position and the pending result.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op        <= opcode;
      id        <= node_id;
      nload     <= new_load;
      nallow    <= new_allowed;
      scan_addr <= ptr_succ;
      iss_cnt   <= '0;
    end else if (issue) begin
      scan_addr <= (scan_addr == LAST_IDX) ? '0 : scan_addr + 1'b1;
      iss_cnt   <= iss_cnt + 1'b1;
    end
    if (issue) begin
      eval_addr <= scan_addr;
    end

    res <= res_next;

    // Output register loads when it is free.
    if ((state == ST_RESP) && out_free) begin
      out_res <= res;
    end
  end

  // A rejected id never carries an announcement.
  a_status_no_announce: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status |-> !out_res.announce)
    else $error("announcement raised on a not-found result");

  // An accepted item starts either a table access or a scan.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_READ) || (state == ST_SCAN))
    else $error("accepted item did not start work");

  // The scan never issues more reads than the table has entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> iss_cnt <= SCAN_LEN)
    else $error("scan overran the table");

  // A finished result waits while the output register is stalled.
  a_resp_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) && !out_free |=> state == ST_RESP)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
